// ===== rtl/oale_pkg.sv =====
// shared types and codes for the ordered array list engine
package oale_pkg;

	// command opcodes
	localparam logic [2:0] OP_APPEND = 3'd0;
	localparam logic [2:0] OP_INSERT = 3'd1;
	localparam logic [2:0] OP_DELETE = 3'd2;
	localparam logic [2:0] OP_SEARCH = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;

	// result status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_BAD_POS  = 2'd2;
	localparam logic [1:0] STAT_NOTFOUND = 2'd3;

	// field widths fixed by the command and result formats
	localparam int POS_W = 7;
	localparam int CNT_W = 8;
	localparam int VAL_W = 32;

	// one command transfer
	typedef struct packed {
		logic [2:0]              opcode;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        position;
	} cmd_t;

	// one result transfer
	typedef struct packed {
		logic [1:0]              status;
		logic [POS_W-1:0]        found_index;
		logic signed [VAL_W-1:0] read_value;
		logic [CNT_W-1:0]        entry_count;
	} rsp_t;

endpackage

// ===== rtl/ordered_array_list_engine_core.sv =====
// ordered array list engine: list storage in one synchronous ram with a shift/search sequencer
// latency: append, rejected commands and unused opcodes give their result in the cycle after the transfer
// read goes through S_READ for the registered ram word; search scans from entry 0 and stops at the first match
// insert shifts up then writes in S_PUT, delete shifts down (one ram entry moved per cycle)
// throughput: one command at a time, busy stays high while the ram walk runs; results cannot stall
// reset clears the entry count and the sequencer; ram contents are undefined until written
module ordered_array_list_engine_core #(
	parameter int CAPACITY = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  oale_pkg::cmd_t   cmd,
	output logic             done,
	output oale_pkg::rsp_t   rsp
);

	localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CW > oale_pkg::POS_W) ? CW : oale_pkg::POS_W;
	localparam int IXW   = (AW > oale_pkg::POS_W) ? AW : oale_pkg::POS_W;
	localparam int CXW   = (CW > oale_pkg::CNT_W) ? CW : oale_pkg::CNT_W;

	// sequencer states
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SHIFT_UP = 3'd1;
	localparam logic [2:0] S_PUT      = 3'd2;
	localparam logic [2:0] S_SHIFT_DN = 3'd3;
	localparam logic [2:0] S_SEARCH   = 3'd4;
	localparam logic [2:0] S_READ     = 3'd5;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] pos_q;
	logic [31:0]   val_q;
	logic          done_q;
	oale_pkg::rsp_t rsp_q;

	logic [31:0]   mem [CAPACITY];
	logic [31:0]   rdata_q;
	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	logic [AW-1:0] raddr;

	logic            acc;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] cnt_x;
	logic [AW-1:0]    pos_a;
	logic             pos_ok;
	logic             full;
	logic             pos_last;
	logic [AW-1:0]    last_a;

	// result field narrowing
	function automatic logic [oale_pkg::CNT_W-1:0] cnt8(input logic [CW-1:0] c);
		logic [CXW-1:0] w;
		w = CXW'(c);
		return w[oale_pkg::CNT_W-1:0];
	endfunction

	function automatic logic [oale_pkg::POS_W-1:0] idx7(input logic [AW-1:0] a);
		logic [IXW-1:0] w;
		w = IXW'(a);
		return w[oale_pkg::POS_W-1:0];
	endfunction

	// command decode
	assign acc      = start && (state_q == S_IDLE);
	assign pos_x    = CMP_W'(cmd.position);
	assign cnt_x    = CMP_W'(count_q);
	assign pos_a    = pos_x[AW-1:0];
	assign pos_ok   = pos_x < cnt_x;
	assign full     = count_q == CW'(CAPACITY);
	assign pos_last = CMP_W'(pos_x + 1'b1) == cnt_x;
	assign last_a   = AW'(count_q - 1'b1);

	// ram port control
	always_comb begin
		we    = 1'b0;
		waddr = ptr_q;
		wdata = rdata_q;
		raddr = ptr_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					unique case (cmd.opcode)
						oale_pkg::OP_APPEND: begin
							we    = !full;
							waddr = count_q[AW-1:0];
							wdata = cmd.value;
						end
						oale_pkg::OP_INSERT: raddr = last_a;
						oale_pkg::OP_DELETE: raddr = AW'(pos_a + 1'b1);
						oale_pkg::OP_SEARCH: raddr = '0;
						default:             raddr = pos_a;
					endcase
				end
			end
			S_SHIFT_UP: begin
				we    = 1'b1;
				waddr = AW'(ptr_q + 1'b1);
				raddr = AW'(ptr_q - 1'b1);
			end
			S_PUT: begin
				we    = 1'b1;
				waddr = pos_q;
				wdata = val_q;
			end
			S_SHIFT_DN: begin
				we    = 1'b1;
				waddr = AW'(ptr_q - 1'b1);
				raddr = AW'(ptr_q + 1'b1);
			end
			S_SEARCH: raddr = AW'(ptr_q + 1'b1);
			default:  raddr = ptr_q;
		endcase
	end

	// list storage, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						val_q <= cmd.value;
						pos_q <= pos_a;
						rsp_q.status      <= oale_pkg::STAT_OK;
						rsp_q.found_index <= '0;
						rsp_q.read_value  <= '0;
						rsp_q.entry_count <= cnt8(count_q);
						unique case (cmd.opcode)
							oale_pkg::OP_APPEND: begin
								done_q <= 1'b1;
								if (full) begin
									rsp_q.status <= oale_pkg::STAT_FULL;
								end else begin
									count_q           <= CW'(count_q + 1'b1);
									rsp_q.entry_count <= cnt8(CW'(count_q + 1'b1));
								end
							end
							oale_pkg::OP_INSERT: begin
								if (!pos_ok) begin
									done_q       <= 1'b1;
									rsp_q.status <= oale_pkg::STAT_BAD_POS;
								end else if (full) begin
									done_q       <= 1'b1;
									rsp_q.status <= oale_pkg::STAT_FULL;
								end else begin
									ptr_q   <= last_a;
									state_q <= S_SHIFT_UP;
								end
							end
							oale_pkg::OP_DELETE: begin
								if (!pos_ok) begin
									done_q       <= 1'b1;
									rsp_q.status <= oale_pkg::STAT_BAD_POS;
								end else if (pos_last) begin
									done_q            <= 1'b1;
									count_q           <= CW'(count_q - 1'b1);
									rsp_q.entry_count <= cnt8(CW'(count_q - 1'b1));
								end else begin
									ptr_q   <= AW'(pos_a + 1'b1);
									state_q <= S_SHIFT_DN;
								end
							end
							oale_pkg::OP_SEARCH: begin
								if (count_q == '0) begin
									done_q       <= 1'b1;
									rsp_q.status <= oale_pkg::STAT_NOTFOUND;
								end else begin
									ptr_q   <= '0;
									state_q <= S_SEARCH;
								end
							end
							oale_pkg::OP_READ: begin
								if (!pos_ok) begin
									done_q       <= 1'b1;
									rsp_q.status <= oale_pkg::STAT_BAD_POS;
								end else begin
									state_q <= S_READ;
								end
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				// move one entry up per cycle, top down
				S_SHIFT_UP: begin
					if (ptr_q == pos_q) begin
						state_q <= S_PUT;
					end else begin
						ptr_q <= AW'(ptr_q - 1'b1);
					end
				end
				// drop the new value into the opened slot
				S_PUT: begin
					done_q            <= 1'b1;
					count_q           <= CW'(count_q + 1'b1);
					rsp_q.entry_count <= cnt8(CW'(count_q + 1'b1));
					state_q           <= S_IDLE;
				end
				// move one entry down per cycle, bottom up
				S_SHIFT_DN: begin
					if (ptr_q == last_a) begin
						done_q            <= 1'b1;
						count_q           <= CW'(count_q - 1'b1);
						rsp_q.entry_count <= cnt8(CW'(count_q - 1'b1));
						state_q           <= S_IDLE;
					end else begin
						ptr_q <= AW'(ptr_q + 1'b1);
					end
				end
				// linear scan, first match wins
				S_SEARCH: begin
					if (rdata_q == val_q) begin
						done_q            <= 1'b1;
						rsp_q.found_index <= idx7(ptr_q);
						state_q           <= S_IDLE;
					end else if (ptr_q == last_a) begin
						done_q       <= 1'b1;
						rsp_q.status <= oale_pkg::STAT_NOTFOUND;
						state_q      <= S_IDLE;
					end else begin
						ptr_q <= AW'(ptr_q + 1'b1);
					end
				end
				S_READ: begin
					done_q           <= 1'b1;
					rsp_q.read_value <= rdata_q;
					state_q          <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

	// count never runs past the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// a result only appears once the sequencer is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy)
		else $error("result issued while busy");

	// the shift never writes the entry being read in the same cycle
	a_shift_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT_UP || state_q == S_SHIFT_DN) |-> (waddr != raddr))
		else $error("shift read and write collide");

	// busy only rises after a command transfer
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy without a command");

	// the scan pointer stays inside the list
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH || state_q == S_SHIFT_DN) |-> (CW'(ptr_q) < count_q))
		else $error("scan pointer beyond count");

endmodule

// ===== bench/ordered_array_list_engine_core_tb.sv =====
// self-checking testbench for the ordered array list engine core
module ordered_array_list_engine_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import oale_pkg::*;

	localparam int CAPACITY = 128;
	localparam int POS_MAX = (1 << POS_W) - 1;
	// longest walk is an insert at the head of a nearly full list
	localparam int DRAIN_CYCLES = CAPACITY + 16;
	localparam int RANDOM_PER_PHASE = 200;
	localparam int TIMEOUT_NS = 10_000_000;

	// opcodes the block treats as no operation
	localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
	localparam logic [2:0] OP_UNUSED_MID = 3'd6;
	localparam logic [2:0] OP_UNUSED_HI  = 3'd7;

	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] FILL_BASE = 32'sh5A5A_0000;

	// sender idle percentage per random phase, phase 0 in the low byte
	localparam logic [3:0][7:0] PHASE_IDLE = {8'd0, 8'd28, 8'd65, 8'd0};

	// one row of the directed plan
	typedef struct packed {
		cmd_t c;
		int   reps;
		bit   typed;
		rsp_t want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic done;
	rsp_t rsp;

	// shadow copy of the list contents and fill level
	logic signed [VAL_W-1:0] shadow_list [CAPACITY];
	int shadow_len = 0;

	rsp_t pending_rsp [$];
	plan_row_t plan [$];
	int err_count = 0;
	int idle_pct = 0;
	bit growing = 1'b1;

	ordered_array_list_engine_core #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.rsp(rsp)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// apply one command to the shadow list and return the result it must give
	function automatic rsp_t apply_list_cmd(input cmd_t c);
		rsp_t r;
		int i;
		bit hit;
		r = '0;
		r.status = STAT_OK;
		hit = 1'b0;
		case (c.opcode)
			OP_APPEND: begin
				if (shadow_len >= CAPACITY) begin
					r.status = STAT_FULL;
				end else begin
					shadow_list[shadow_len] = c.value;
					shadow_len++;
				end
			end
			OP_INSERT: begin
				// position check wins over the full check
				if (int'(c.position) >= shadow_len) begin
					r.status = STAT_BAD_POS;
				end else if (shadow_len >= CAPACITY) begin
					r.status = STAT_FULL;
				end else begin
					for (i = shadow_len; i > int'(c.position); i--)
						shadow_list[i] = shadow_list[i-1];
					shadow_list[c.position] = c.value;
					shadow_len++;
				end
			end
			OP_DELETE: begin
				if (int'(c.position) >= shadow_len) begin
					r.status = STAT_BAD_POS;
				end else begin
					for (i = int'(c.position); i + 1 < shadow_len; i++)
						shadow_list[i] = shadow_list[i+1];
					shadow_len--;
				end
			end
			OP_SEARCH: begin
				r.status = STAT_NOTFOUND;
				for (i = 0; i < shadow_len && !hit; i++) begin
					if (shadow_list[i] == c.value) begin
						hit = 1'b1;
						r.status = STAT_OK;
						r.found_index = i[POS_W-1:0];
					end
				end
			end
			OP_READ: begin
				if (int'(c.position) >= shadow_len)
					r.status = STAT_BAD_POS;
				else
					r.read_value = shadow_list[c.position];
			end
			default: begin
			end
		endcase
		r.entry_count = shadow_len[CNT_W-1:0];
		return r;
	endfunction

	// random command that keeps the list moving between empty and full
	function automatic cmd_t next_random_cmd();
		cmd_t c;
		int roll;
		c = '0;
		if (growing && shadow_len == CAPACITY && $urandom_range(0, 3) == 0)
			growing = 1'b0;
		else if (!growing && shadow_len == 0 && $urandom_range(0, 3) == 0)
			growing = 1'b1;
		else if ($urandom_range(0, 99) == 0)
			growing = !growing;

		// operation mix depends on the fill direction
		roll = $urandom_range(0, 99);
		if (roll < 5)
			c.opcode = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
		else if (roll < 20)
			c.opcode = OP_SEARCH;
		else if (roll < 35)
			c.opcode = OP_READ;
		else if (roll < (growing ? 65 : 45))
			c.opcode = OP_APPEND;
		else if (roll < (growing ? 90 : 55))
			c.opcode = OP_INSERT;
		else
			c.opcode = OP_DELETE;

		// few distinct values so searches meet duplicates, plus extremes and full range
		roll = $urandom_range(0, 99);
		if (roll < 40) begin
			c.value = $urandom_range(0, 15);
		end else if (roll < 50) begin
			case ($urandom_range(0, 3))
				0: c.value = VAL_MIN;
				1: c.value = VAL_MAX;
				2: c.value = '0;
				default: c.value = '1;
			endcase
		end else begin
			c.value = $urandom;
		end
		if (c.opcode == OP_SEARCH && shadow_len > 0 && $urandom_range(0, 1) == 1)
			c.value = shadow_list[$urandom_range(0, shadow_len - 1)];

		// mostly valid positions, some at the fill level, some anywhere
		roll = $urandom_range(0, 99);
		if (roll < 70 && shadow_len > 0)
			c.position = POS_W'($urandom_range(0, shadow_len - 1));
		else if (roll < 80 && shadow_len < CAPACITY)
			c.position = shadow_len[POS_W-1:0];
		else
			c.position = POS_W'($urandom_range(0, POS_MAX));
		return c;
	endfunction

	task automatic add_checked(input logic [2:0] op, input logic signed [VAL_W-1:0] val,
			input logic [POS_W-1:0] pos, input logic [1:0] st,
			input logic [POS_W-1:0] idx, input logic signed [VAL_W-1:0] rd,
			input logic [CNT_W-1:0] cnt);
		plan_row_t row;
		row.c.opcode = op;
		row.c.value = val;
		row.c.position = pos;
		row.reps = 1;
		row.typed = 1'b1;
		row.want.status = st;
		row.want.found_index = idx;
		row.want.read_value = rd;
		row.want.entry_count = cnt;
		plan.push_back(row);
	endtask

	task automatic add_predicted(input logic [2:0] op, input logic signed [VAL_W-1:0] val,
			input logic [POS_W-1:0] pos, input int reps);
		plan_row_t row;
		row.c.opcode = op;
		row.c.value = val;
		row.c.position = pos;
		row.reps = reps;
		row.typed = 1'b0;
		row.want = '0;
		plan.push_back(row);
	endtask

	// one command transfer; called at a falling edge, returns at a falling edge
	task automatic send_cmd(input cmd_t c, input bit typed, input rsp_t want);
		rsp_t predicted;
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		predicted = apply_list_cmd(c);
		pending_rsp.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	// compare each result with the oldest expectation
	always @(posedge clk) begin : result_check
		rsp_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected result st=%0d idx=%0d rd=%0d cnt=%0d", $time,
					rsp.status, rsp.found_index, rsp.read_value, rsp.entry_count);
				err_count++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status || rsp.found_index !== want.found_index ||
						rsp.read_value !== want.read_value ||
						rsp.entry_count !== want.entry_count) begin
					$display({"%0t: mismatch expected st=%0d idx=%0d rd=%0d cnt=%0d",
						" actual st=%0d idx=%0d rd=%0d cnt=%0d"}, $time,
						want.status, want.found_index, want.read_value, want.entry_count,
						rsp.status, rsp.found_index, rsp.read_value, rsp.entry_count);
					err_count++;
				end
			end
		end
	end

	// stimulus
	initial begin : stimulus
		cmd_t c;
		int k;
		int n;
		int ph;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		for (k = 0; k < CAPACITY; k++)
			shadow_list[k] = '0;

		// empty list edge cases
		add_checked(OP_READ, 0, 0, STAT_BAD_POS, 0, 0, 0);
		add_checked(OP_DELETE, 0, 0, STAT_BAD_POS, 0, 0, 0);
		add_checked(OP_INSERT, 5, 0, STAT_BAD_POS, 0, 0, 0);
		add_checked(OP_SEARCH, 0, 0, STAT_NOTFOUND, 0, 0, 0);
		// value extremes and positions around the fill level
		add_checked(OP_APPEND, VAL_MIN, 0, STAT_OK, 0, 0, 1);
		add_checked(OP_APPEND, VAL_MAX, 0, STAT_OK, 0, 0, 2);
		add_checked(OP_READ, 0, 0, STAT_OK, 0, VAL_MIN, 2);
		add_checked(OP_READ, 0, 1, STAT_OK, 0, VAL_MAX, 2);
		add_checked(OP_READ, 0, 2, STAT_BAD_POS, 0, 0, 2);
		add_checked(OP_INSERT, -1, 2, STAT_BAD_POS, 0, 0, 2);
		add_checked(OP_INSERT, -1, 0, STAT_OK, 0, 0, 3);
		add_checked(OP_SEARCH, VAL_MAX, 0, STAT_OK, 2, 0, 3);
		add_checked(OP_SEARCH, 0, 0, STAT_NOTFOUND, 0, 0, 3);
		// unused opcodes leave the list alone
		add_checked(OP_UNUSED_LO, VAL_MAX, POS_MAX, STAT_OK, 0, 0, 3);
		add_checked(OP_UNUSED_MID, VAL_MIN, 0, STAT_OK, 0, 0, 3);
		add_checked(OP_UNUSED_HI, -1, POS_MAX, STAT_OK, 0, 0, 3);
		add_checked(OP_DELETE, 0, 2, STAT_OK, 0, 0, 2);
		add_checked(OP_READ, 0, POS_MAX, STAT_BAD_POS, 0, 0, 2);
		// fill to capacity, then the full cases
		add_predicted(OP_APPEND, FILL_BASE, 0, CAPACITY - 2);
		add_checked(OP_APPEND, 7, 0, STAT_FULL, 0, 0, CAPACITY);
		add_checked(OP_INSERT, 7, POS_MAX, STAT_FULL, 0, 0, CAPACITY);
		add_checked(OP_INSERT, 7, 0, STAT_FULL, 0, 0, CAPACITY);
		add_predicted(OP_READ, 0, POS_MAX, 1);
		add_predicted(OP_SEARCH, FILL_BASE + CAPACITY - 3, 0, 1);
		add_predicted(OP_DELETE, 0, 0, CAPACITY);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed plan, no idling
		idle_pct = 0;
		foreach (plan[k]) begin
			for (n = 0; n < plan[k].reps; n++) begin
				c = plan[k].c;
				c.value = plan[k].c.value + n;
				send_cmd(c, plan[k].typed, plan[k].want);
			end
		end

		// random phases with different sender idling
		for (ph = 0; ph < 4; ph++) begin
			idle_pct = int'(PHASE_IDLE[ph]);
			for (n = 0; n < RANDOM_PER_PHASE; n++)
				send_cmd(next_random_cmd(), 1'b0, '0);
		end
		start <= 1'b0;

		// wait for every result, then a quiet stretch
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("PASS ordered_array_list_engine_core");
		else
			$display("FAIL ordered_array_list_engine_core");
		$finish;
	end

	// watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("FAIL ordered_array_list_engine_core");
		$finish;
	end

endmodule
